/* rtl/asl_pkg.sv */
// Shared types and constants for the address range lookup block.
package asl_pkg;

	// Fixed field widths
	localparam int DATA_W    = 64;
	localparam int SYM_W     = 10;
	localparam int ENT_IDX_W = 10;
	localparam int CNT_REG_W = 11;

	// Configuration port: two 64-bit registers at byte offsets 0 and 8
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;

	// Default table depth
	localparam int DEF_TABLE_DEPTH = 1024;

	// Register indexes (paddr[3])
	localparam logic REG_LOAD_BIAS   = 1'b0;
	localparam logic REG_ENTRY_COUNT = 1'b1;

	// Command codes
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// One table entry as stored in the RAM
	typedef struct packed {
		logic [DATA_W-1:0] start_addr;
		logic [DATA_W-1:0] end_addr;
	} entry_t;

	// One lookup result
	typedef struct packed {
		logic              hit;
		logic [SYM_W-1:0]  idx;
		logic [DATA_W-1:0] start_addr;
		logic [DATA_W-1:0] end_addr;
		logic [DATA_W-1:0] offset;
		logic [DATA_W-1:0] pc;
	} result_t;

endpackage

/* rtl/asl_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
module asl_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = asl_pkg::DEF_TABLE_DEPTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/asl_search.sv */
// Binary search sequencer: one table probe per cycle, one shared start compare.
module asl_search #(
	parameter int TABLE_DEPTH = asl_pkg::DEF_TABLE_DEPTH,
	localparam int IDX_W = $clog2(TABLE_DEPTH),
	localparam int CNT_W = IDX_W + 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [asl_pkg::DATA_W-1:0]  query_addr,
	input  logic [asl_pkg::DATA_W-1:0]  load_bias,
	input  logic [CNT_W-1:0]            count,
	output logic                        rd_en,
	output logic [IDX_W-1:0]            rd_addr,
	input  asl_pkg::entry_t             rd_entry,
	output logic                        busy,
	output logic                        done,
	output asl_pkg::result_t            res
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_PROBE,
		S_CHECK
	} state_t;

	state_t                       state_q;
	logic [asl_pkg::DATA_W-1:0]   addr_q;
	logic [asl_pkg::DATA_W-1:0]   pc_q;
	logic                         second_q;
	logic [CNT_W-1:0]             lo_q;
	logic [CNT_W-1:0]             hi_q;
	logic [CNT_W-1:0]             mid_q;
	logic                         cand_valid_q;
	logic [IDX_W-1:0]             cand_idx_q;
	asl_pkg::entry_t              cand_q;
	logic                         done_q;
	asl_pkg::result_t             res_q;

	logic                         go_right;
	logic [CNT_W-1:0]             lo_n;
	logic [CNT_W-1:0]             hi_n;
	logic [CNT_W-1:0]             mid_start;
	logic [CNT_W-1:0]             mid_n;
	logic                         cand_cover;
	logic                         cand_hit;
	logic [asl_pkg::DATA_W-1:0]   cand_off;

	// Shared compare: probed start against the search address
	assign go_right  = (rd_entry.start_addr <= addr_q);
	assign lo_n      = go_right ? (mid_q + CNT_W'(1)) : lo_q;
	assign hi_n      = go_right ? hi_q : mid_q;
	assign mid_start = lo_q + ((hi_q - lo_q) >> 1);
	assign mid_n     = lo_n + ((hi_n - lo_n) >> 1);

	// Hit test on the candidate (last probe that went right)
	assign cand_cover = (cand_q.end_addr > cand_q.start_addr) ? (addr_q < cand_q.end_addr)
	                                                          : (addr_q == cand_q.start_addr);
	assign cand_hit = cand_valid_q && (addr_q >= cand_q.start_addr) && cand_cover;
	assign cand_off = addr_q - cand_q.start_addr;

	// RAM read request
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid_start[IDX_W-1:0];
		unique case (state_q)
			S_START: begin
				rd_en   = (lo_q < hi_q);
				rd_addr = mid_start[IDX_W-1:0];
			end
			S_PROBE: begin
				rd_en   = (lo_n < hi_n);
				rd_addr = mid_n[IDX_W-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			second_q     <= 1'b0;
			cand_valid_q <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (go) begin
						addr_q       <= query_addr - load_bias;
						pc_q         <= query_addr;
						second_q     <= 1'b0;
						lo_q         <= '0;
						hi_q         <= count;
						cand_valid_q <= 1'b0;
						state_q      <= S_START;
					end
				end
				S_START: begin
					mid_q <= mid_start;
					if (lo_q < hi_q) begin
						state_q <= S_PROBE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_PROBE: begin
					if (go_right) begin
						cand_q       <= rd_entry;
						cand_idx_q   <= mid_q[IDX_W-1:0];
						cand_valid_q <= 1'b1;
					end
					lo_q  <= lo_n;
					hi_q  <= hi_n;
					mid_q <= mid_n;
					if (!(lo_n < hi_n)) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (cand_hit || second_q || (load_bias == '0)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (cand_hit) begin
							res_q.hit        <= 1'b1;
							res_q.idx        <= asl_pkg::SYM_W'(cand_idx_q);
							res_q.start_addr <= cand_q.start_addr;
							res_q.end_addr   <= cand_q.end_addr;
							res_q.offset     <= cand_off;
							res_q.pc         <= addr_q;
						end else begin
							res_q <= '0;
						end
					end else begin
						// Retry with the unadjusted address
						addr_q       <= pc_q;
						second_q     <= 1'b1;
						lo_q         <= '0;
						hi_q         <= count;
						cand_valid_q <= 1'b0;
						state_q      <= S_START;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule

/* rtl/address_range_symbol_lookup.sv */
// Top level of the address range lookup: config registers, table RAM, search.
//
//  channel   handshake                   payload
//  -------   -------------------------   ------------------------------------------
//  command   start / busy                command, entry_index, entry_start,
//                                        entry_end, query_addr
//  result    done (one-cycle strobe)     hit, symbol_index, symbol_start,
//                                        symbol_end, offset, static_pc
//  config    psel/penable/pwrite/pready  paddr (0: load_bias, 8: entry_count), pwdata
//
// A write command takes the cycle it is accepted in; busy stays low.
// A lookup runs one search pass of ceil(log2(n+1)) probes, one per cycle on the
// table RAM read port, plus a start and a check state; a miss with nonzero bias
// runs a second pass.
// done pulses the cycle after the last check; the receiver cannot stall it.
// Reset clears the config registers and the sequencer state; the table RAM holds no reset.
module address_range_symbol_lookup #(
	parameter int TABLE_DEPTH = asl_pkg::DEF_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [asl_pkg::ENT_IDX_W-1:0] entry_index,
	input  logic [asl_pkg::DATA_W-1:0]    entry_start,
	input  logic [asl_pkg::DATA_W-1:0]    entry_end,
	input  logic [asl_pkg::DATA_W-1:0]    query_addr,
	// result channel
	output logic                          done,
	output logic                          hit,
	output logic [asl_pkg::SYM_W-1:0]     symbol_index,
	output logic [asl_pkg::DATA_W-1:0]    symbol_start,
	output logic [asl_pkg::DATA_W-1:0]    symbol_end,
	output logic [asl_pkg::DATA_W-1:0]    offset,
	output logic [asl_pkg::DATA_W-1:0]    static_pc,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [asl_pkg::PADDR_W-1:0]   paddr,
	input  logic [asl_pkg::PDATA_W-1:0]   pwdata,
	output logic [asl_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = IDX_W + 1;
	localparam int ENT_W = $bits(asl_pkg::entry_t);

	logic [asl_pkg::DATA_W-1:0]    load_bias_q;
	logic [asl_pkg::CNT_REG_W-1:0] entry_count_q;
	logic                          cfg_wr;
	logic                          accept;
	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	asl_pkg::entry_t               wr_entry;
	logic                          rd_en;
	logic [IDX_W-1:0]              rd_addr;
	logic [ENT_W-1:0]              rd_data;
	asl_pkg::entry_t               rd_entry;
	logic [CNT_W-1:0]              active_cnt;
	logic                          lookup_go;
	asl_pkg::result_t              res;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_bias_q   <= '0;
			entry_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				asl_pkg::REG_LOAD_BIAS:   load_bias_q   <= pwdata;
				asl_pkg::REG_ENTRY_COUNT: entry_count_q <= pwdata[asl_pkg::CNT_REG_W-1:0];
				default:                  load_bias_q   <= load_bias_q;
			endcase
		end
	end

	assign prdata = (paddr[3] == asl_pkg::REG_ENTRY_COUNT)
	              ? asl_pkg::PDATA_W'(entry_count_q) : load_bias_q;

	// Entry count saturated to the table depth
	assign active_cnt = (32'(entry_count_q) > 32'(TABLE_DEPTH))
	                  ? CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_q);

	// Command acceptance
	assign accept    = start && !busy;
	assign lookup_go = accept && (command == asl_pkg::CMD_LOOKUP);
	assign wr_en     = accept && (command == asl_pkg::CMD_WRITE)
	                 && (32'(entry_index) < 32'(TABLE_DEPTH));
	assign wr_addr   = IDX_W'(entry_index);
	assign wr_entry  = '{start_addr: entry_start, end_addr: entry_end};

	// Range table
	asl_ram #(
		.WIDTH (ENT_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_entry = asl_pkg::entry_t'(rd_data);

	// Search sequencer
	asl_search #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (lookup_go),
		.query_addr (query_addr),
		.load_bias  (load_bias_q),
		.count      (active_cnt),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_entry   (rd_entry),
		.busy       (busy),
		.done       (done),
		.res        (res)
	);

	assign hit          = res.hit;
	assign symbol_index = res.idx;
	assign symbol_start = res.start_addr;
	assign symbol_end   = res.end_addr;
	assign offset       = res.offset;
	assign static_pc    = res.pc;

	// Result strobe only while the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while search still running");

	// Table writes never occupy the sequencer
	a_write_quick: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == asl_pkg::CMD_WRITE)) |=> !busy)
		else $error("write transaction left the block busy");

	// A lookup always starts a search
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == asl_pkg::CMD_LOOKUP)) |=> (busy && !done))
		else $error("lookup transaction did not start a search");

	// Miss results carry all-zero payload
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> ((symbol_index == '0) && (symbol_start == '0)
		                 && (symbol_end == '0) && (offset == '0) && (static_pc == '0)))
		else $error("miss result with nonzero payload");

endmodule

/* tb/lookup_checker.sv */
// Checker for the address range lookup: predicts each lookup and compares the results.
`timescale 1ns / 100ps

module lookup_checker
	import asl_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// command channel
	input  logic                 start,
	input  logic                 busy,
	input  logic                 command,
	input  logic [ENT_IDX_W-1:0] entry_index,
	input  logic [DATA_W-1:0]    entry_start,
	input  logic [DATA_W-1:0]    entry_end,
	input  logic [DATA_W-1:0]    query_addr,
	// result channel
	input  logic                 done,
	input  logic                 hit,
	input  logic [SYM_W-1:0]     symbol_index,
	input  logic [DATA_W-1:0]    symbol_start,
	input  logic [DATA_W-1:0]    symbol_end,
	input  logic [DATA_W-1:0]    offset,
	input  logic [DATA_W-1:0]    static_pc,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	input  logic                 pready,
	// status to the top
	output int                   fail_count,
	output int                   pending
);

	// Shadow copy of the table and registers
	logic [DATA_W-1:0]    range_lo [TABLE_DEPTH];
	logic [DATA_W-1:0]    range_hi [TABLE_DEPTH];
	logic [DATA_W-1:0]    bias_reg;
	logic [CNT_REG_W-1:0] count_reg;

	// Lookups accepted, waiting for their result strobe
	result_t pending_lookups [$];

	// Binary search over the active entries; fixed probe order, sorted or not
	function automatic bit find_range(input logic [DATA_W-1:0] addr, output int unsigned idx);
		int unsigned n;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		idx = 0;
		n = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
		lo = 0;
		hi = n;
		if (n == 0)
			return 1'b0;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (range_lo[mid] <= addr)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo == 0)
			return 1'b0;
		idx = lo - 1;
		if (addr < range_lo[idx])
			return 1'b0;
		// end not above start: the range is the start address alone
		if (range_hi[idx] > range_lo[idx])
			return addr < range_hi[idx];
		return addr == range_lo[idx];
	endfunction

	// Biased search first, then the raw pc when a nonzero bias missed
	function automatic result_t resolve_pc(input logic [DATA_W-1:0] pc);
		result_t          r;
		logic [DATA_W-1:0] addr;
		int unsigned      idx;
		bit               found;
		r = '0;
		addr = pc - bias_reg;
		found = find_range(addr, idx);
		if (!found && bias_reg != '0) begin
			addr = pc;
			found = find_range(addr, idx);
		end
		if (found) begin
			r.hit        = 1'b1;
			r.idx        = idx[SYM_W-1:0];
			r.start_addr = range_lo[idx];
			r.end_addr   = range_hi[idx];
			r.offset     = addr - range_lo[idx];
			r.pc         = addr;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		if (!arst_n) begin
			bias_reg   = '0;
			count_reg  = '0;
			fail_count = 0;
			pending_lookups.delete();
			pending <= 0;
		end else begin
			// result transaction against the oldest prediction
			if (done) begin
				if (pending_lookups.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result strobe with no lookup outstanding", $time);
				end else begin
					want = pending_lookups.pop_front();
					if (hit !== want.hit || symbol_index !== want.idx ||
					    symbol_start !== want.start_addr || symbol_end !== want.end_addr ||
					    offset !== want.offset || static_pc !== want.pc) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: lookup result mismatch", $time);
							$display("  expected hit=%0b idx=%0d start=%h end=%h off=%h pc=%h",
							         want.hit, want.idx, want.start_addr, want.end_addr,
							         want.offset, want.pc);
							$display("  actual   hit=%0b idx=%0d start=%h end=%h off=%h pc=%h",
							         hit, symbol_index, symbol_start, symbol_end, offset,
							         static_pc);
						end
					end
				end
			end

			// register write
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_LOAD_BIAS)
					bias_reg = pwdata[DATA_W-1:0];
				else
					count_reg = pwdata[CNT_REG_W-1:0];
			end

			// command transaction
			if (start && !busy) begin
				if (command == CMD_WRITE) begin
					range_lo[entry_index] = entry_start;
					range_hi[entry_index] = entry_end;
				end else begin
					pending_lookups = {pending_lookups, resolve_pc(query_addr)};
				end
			end

			pending <= pending_lookups.size();
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the address range lookup testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
	import asl_pkg::*;

	localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
	localparam int ITEM_TARGET = 1950;
	localparam int FILL_AT     = 600;
	localparam int SETTLE_CYC  = 30;
	localparam int STALL_LIMIT = 4000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic                 command;
	logic [ENT_IDX_W-1:0] entry_index;
	logic [DATA_W-1:0]    entry_start;
	logic [DATA_W-1:0]    entry_end;
	logic [DATA_W-1:0]    query_addr;
	logic                 done;
	logic                 hit;
	logic [SYM_W-1:0]     symbol_index;
	logic [DATA_W-1:0]    symbol_start;
	logic [DATA_W-1:0]    symbol_end;
	logic [DATA_W-1:0]    offset;
	logic [DATA_W-1:0]    static_pc;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	int fail_count;
	int pending;
	int items_sent;
	int stall_cycles = 0;

	// Copy of what was written, used to aim lookups at ranges and to keep a start on rewrites
	logic [DATA_W-1:0] tbl_start [TABLE_DEPTH];
	logic [DATA_W-1:0] tbl_end   [TABLE_DEPTH];

	always #10 clk = ~clk;

	address_range_symbol_lookup #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
		.clk, .arst_n, .start, .busy, .command, .entry_index, .entry_start, .entry_end,
		.query_addr, .done, .hit, .symbol_index, .symbol_start, .symbol_end, .offset,
		.static_pc, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	lookup_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
		.clk, .arst_n, .start, .busy, .command, .entry_index, .entry_start, .entry_end,
		.query_addr, .done, .hit, .symbol_index, .symbol_start, .symbol_end, .offset,
		.static_pc, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.fail_count, .pending
	);

	// Watchdog: cycles in which no transaction of any kind completes
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("** address_range_symbol_lookup: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// One command transaction; start stays high when the next one follows at once
	task automatic issue(input logic cmd, input logic [ENT_IDX_W-1:0] idx,
	                     input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] e,
	                     input logic [DATA_W-1:0] pc);
		int gap_pct;
		gap_pct = (items_sent < 650) ? 15 : (items_sent < 1300) ? 58 : 0;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		start       <= 1'b1;
		command     <= cmd;
		entry_index <= idx;
		entry_start <= s;
		entry_end   <= e;
		query_addr  <= pc;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic write_entry(input int unsigned idx, input logic [DATA_W-1:0] s,
	                           input logic [DATA_W-1:0] e);
		tbl_start[idx] = s;
		tbl_end[idx]   = e;
		issue(CMD_WRITE, idx[ENT_IDX_W-1:0], s, e, {$urandom, $urandom});
	endtask

	task automatic lookup(input logic [DATA_W-1:0] pc);
		issue(CMD_LOOKUP, ENT_IDX_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom}, pc);
	endtask

	// Drop start, wait out every lookup, then let the block go quiet
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle
	task automatic write_reg(input logic sel, input logic [PDATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Fill slots 0..n-1, ascending from a random base unless scrambled
	task automatic load_table(input int unsigned n, input bit scrambled);
		logic [DATA_W-1:0] s;
		logic [DATA_W-1:0] e;
		case ($urandom_range(3))
			0: s = '0;
			1: s = ~64'd0 - 64'(n) * 64'h400;
			2: s = {$urandom, $urandom};
			default: s = {32'd0, $urandom};
		endcase
		for (int unsigned i = 0; i < n; i++) begin
			if (scrambled)
				s = {$urandom, $urandom};
			else if (i != 0)
				s = s + 64'($urandom_range(0, 'h400));   // zero step gives a tie
			case ($urandom_range(9))
				0: e = s;
				1: e = s - 64'($urandom_range(1, 'hff));
				2: e = ~64'd0;
				default: e = s + 64'($urandom_range(1, 'h300));
			endcase
			write_entry(i, s, e);
		end
	endtask

	// Runtime pc aimed at, around, or away from one of the first n ranges
	function automatic logic [DATA_W-1:0] pick_pc(input int unsigned n,
	                                               input logic [DATA_W-1:0] bias);
		int unsigned       k;
		int unsigned       sel;
		logic [DATA_W-1:0] s;
		logic [DATA_W-1:0] e;
		logic [DATA_W-1:0] span;
		logic [DATA_W-1:0] addr;
		addr = {$urandom, $urandom};
		if (n != 0) begin
			k = $urandom_range(n - 1);
			s = tbl_start[k];
			e = tbl_end[k];
			span = (e > s) ? e - s : 64'd1;
			sel = $urandom_range(99);
			if (sel < 55)
				addr = s + ({$urandom, $urandom} % span);
			else if (sel < 65)
				addr = s;
			else if (sel < 75)
				addr = e - 1;
			else if (sel < 82)
				addr = e;
			else if (sel < 88)
				addr = s - 1;
		end
		// mostly the loaded (biased) form; the rest exercises the raw-pc retry
		if ($urandom_range(99) < 80)
			addr = addr + bias;
		return addr;
	endfunction

	initial begin
		logic [DATA_W-1:0]    bias;
		logic [CNT_REG_W-1:0] count;
		int unsigned          live;
		int unsigned          k;
		int                   n_lookups;
		int                   big_step;
		bit                   table_full;
		bit                   big;

		arst_n      <= 1'b0;
		start       <= 1'b0;
		command     <= CMD_WRITE;
		entry_index <= '0;
		entry_start <= '0;
		entry_end   <= '0;
		query_addr  <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		items_sent   = 0;
		table_full   = 1'b0;
		big_step     = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: every lookup misses
		lookup('0);
		lookup(~64'd0);

		// small sorted table with single-address entries, a tie and the extremes
		write_entry(0, 64'h0, 64'h100);
		write_entry(1, 64'h100, 64'h100);
		write_entry(2, 64'h1000, 64'h2000);
		write_entry(3, 64'h1000, 64'h1800);
		write_entry(4, 64'h8000_0000_0000_0000, 64'h10);
		write_entry(5, ~64'd0, ~64'd0);
		write_entry(TABLE_DEPTH - 1, ~64'd0, '0);
		settle();
		write_reg(REG_LOAD_BIAS, '0);
		write_reg(REG_ENTRY_COUNT, 64'd6);
		lookup(64'h50);
		lookup(64'h100);
		lookup(64'h101);
		lookup(64'h1fff);
		lookup(64'h1400);
		lookup(64'h8000_0000_0000_0000);
		lookup(~64'd0);

		// bias wraps some addresses below zero; the raw pc then hits
		settle();
		write_reg(REG_LOAD_BIAS, 64'h1000);
		lookup(64'h1050);
		lookup(64'h20);
		settle();
		write_reg(REG_LOAD_BIAS, ~64'd0);
		lookup(64'hff);

		// random phases: new settings, optional table reload, then a burst of lookups
		while (items_sent < ITEM_TARGET) begin
			settle();
			if (!table_full && items_sent >= FILL_AT) begin
				load_table(TABLE_DEPTH, 1'b0);
				table_full = 1'b1;
				settle();
			end
			big = table_full && (big_step < 2 || $urandom_range(1) == 1);
			if (big) begin
				case (big_step)
					0: count = 11'd2047;
					1: count = 11'd1024;
					default: begin
						case ($urandom_range(2))
							0: count = 11'($urandom_range(1025, 2047));
							1: count = 11'd1024;
							default: count = 11'($urandom_range(100, 1023));
						endcase
					end
				endcase
				big_step++;
			end else begin
				count = ($urandom_range(9) == 0) ? '0 : 11'($urandom_range(1, 24));
				// once the full table is in, keep it sorted for the large phases
				if (!table_full) begin
					load_table(count, $urandom_range(99) < 10);
					settle();
				end
			end
			case ($urandom_range(4))
				0: bias = '0;
				1: bias = ~64'd0;
				2: bias = {32'd0, $urandom_range(1, 'hffff)};
				default: bias = {$urandom, $urandom};
			endcase
			write_reg(REG_LOAD_BIAS, bias);
			write_reg(REG_ENTRY_COUNT, {53'd0, count});
			live = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;

			n_lookups = $urandom_range(15, 40);
			for (int i = 0; i < n_lookups; i++) begin
				if ($urandom_range(99) < 7) begin
					// stray table write; after the fill only the end changes
					k = $urandom_range(TABLE_DEPTH - 1);
					if (table_full)
						write_entry(k, tbl_start[k], {$urandom, $urandom});
					else
						write_entry(k, {$urandom, $urandom}, {$urandom, $urandom});
				end else begin
					lookup(pick_pc(live, bias));
				end
			end
		end

		settle();
		if (fail_count == 0 && pending == 0)
			$display("** address_range_symbol_lookup: PASSED **");
		else
			$display("** address_range_symbol_lookup: FAILED **");
		$finish;
	end

endmodule
